FILE: sv/fat_root_file_locator_top_macros.svh
// Assertion macros shared by the root file locator modules.
// Needs signals clk and rst_n in the module that uses them.
`ifndef FAT_ROOT_FILE_LOCATOR_TOP_MACROS_SVH
`define FAT_ROOT_FILE_LOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset
`define FRFL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define FRFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FRFL_ASSERT_IMPL(label, ante, cons, msg)
`define FRFL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: sv/frfl_pkg.sv
// Shared types and constants for the FAT16 root directory file locator.
// No dependencies; used by every module of the block.
package frfl_pkg;

    localparam int OFF_W     = 36;
    localparam int BYTE_W    = 8;
    localparam int NAME_W    = 64;
    localparam int EXT_W     = 24;
    localparam int STATUS_W  = 3;
    localparam int FOFF_W    = 41;
    localparam int CLUS_W    = 16;
    localparam int CIDX_W    = 1;
    // root sector count as carried to the offset stage (limit is at most 256)
    localparam int RS_W      = 9;
    // root sector count before the range check: ceil(65535 / 16) needs 13 bits
    localparam int RS_CALC_W = 13;

    localparam int DEF_MAX_ROOT_SECTORS = 64;

    localparam logic [23:0]       BOOT_SIG     = 24'hEB3C90;
    localparam logic [15:0]       SECTOR_BYTES = 16'd512;
    localparam logic [NAME_W-1:0] NAME_RESET   = 64'h2020202020202020;
    localparam logic [EXT_W-1:0]  EXT_RESET    = 24'h202020;

    // boot sector byte offsets
    localparam logic [4:0] BOOT_JMP0  = 5'd0;
    localparam logic [4:0] BOOT_JMP1  = 5'd1;
    localparam logic [4:0] BOOT_JMP2  = 5'd2;
    localparam logic [4:0] BOOT_BPS0  = 5'd11;
    localparam logic [4:0] BOOT_BPS1  = 5'd12;
    localparam logic [4:0] BOOT_SPC   = 5'd13;
    localparam logic [4:0] BOOT_RSV0  = 5'd14;
    localparam logic [4:0] BOOT_RSV1  = 5'd15;
    localparam logic [4:0] BOOT_NFAT  = 5'd16;
    localparam logic [4:0] BOOT_RENT0 = 5'd17;
    localparam logic [4:0] BOOT_RENT1 = 5'd18;
    localparam logic [4:0] BOOT_FATS0 = 5'd22;
    localparam logic [4:0] BOOT_LAST  = 5'd23;

    // directory entry byte positions
    localparam logic [4:0] ENT_NAME0 = 5'd0;
    localparam logic [4:0] ENT_NAME1 = 5'd1;
    localparam logic [4:0] ENT_NAME7 = 5'd7;
    localparam logic [4:0] ENT_EXT0  = 5'd8;
    localparam logic [4:0] ENT_EXT2  = 5'd10;
    localparam logic [4:0] ENT_CLUS0 = 5'd26;
    localparam logic [4:0] ENT_CLUS1 = 5'd27;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_WANTED_NAME = 1'b0;
    localparam logic [CIDX_W-1:0] REG_WANTED_EXT  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_SIG   = 3'd1,
        ST_BAD_SECT  = 3'd2,
        ST_BAD_ROOT  = 3'd3,
        ST_NOT_FOUND = 3'd4
    } frfl_status_t;

    // result candidate handed from the scan stage to the offset stages
    typedef struct packed {
        frfl_status_t      status;
        logic [CLUS_W-1:0] cluster;
        logic [OFF_W-1:0]  root_start;
        logic [RS_W-1:0]   root_sects;
        logic [7:0]        clus_sects;
    } frfl_cand_t;

endpackage

FILE: sv/frfl_scan.sv
// Input register, boot sector capture and checks, root entry matching.
// Depends on frfl_pkg and the assertion macro header.
`include "fat_root_file_locator_top_macros.svh"

module frfl_scan
    import frfl_pkg::*;
#(
    parameter int MAX_ROOT_SECTORS = DEF_MAX_ROOT_SECTORS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              start_search,
    input  logic [OFF_W-1:0]  byte_offset,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              stream_end,
    input  logic [NAME_W-1:0] wanted_name,
    input  logic [EXT_W-1:0]  wanted_ext,
    output logic              cand_valid,
    output frfl_cand_t        cand,
    input  logic              cand_stall
);

    localparam logic [RS_CALC_W-1:0] RS_LIMIT = RS_CALC_W'(MAX_ROOT_SECTORS);

    // input register
    logic              s0_v_reg;
    logic              s0_start_reg;
    logic [OFF_W-1:0]  s0_off_reg;
    logic [BYTE_W-1:0] s0_val_reg;
    logic              s0_last_reg;

    // search state
    logic [23:0]       sig_reg,        sig_next,        sig_eff;
    logic [15:0]       ssize_reg,      ssize_next,      ssize_eff;
    logic [15:0]       resv_reg,       resv_next,       resv_eff;
    logic [7:0]        fatn_reg,       fatn_next,       fatn_eff;
    logic [15:0]       fats_reg,       fats_next,       fats_eff;
    logic [15:0]       rent_reg,       rent_next,       rent_eff;
    logic [7:0]        csect_reg,      csect_next,      csect_eff;
    logic [OFF_W-1:0]  root_start_reg, root_start_next, root_start_eff;
    logic [RS_W-1:0]   root_sects_reg, root_sects_next, root_sects_eff;
    logic              match_reg,      match_next,      match_eff;
    logic [CLUS_W-1:0] clus_reg,       clus_next,       clus_eff;
    logic              done_reg,       done_next,       done_eff;
    logic              boot_ok_reg,    boot_ok_next,    boot_ok_eff;

    // result candidate register
    logic              cand_v_reg, cand_v_next;
    frfl_cand_t        cand_reg,   cand_next;

    logic              cand_free;
    logic              s0_move;
    logic              in_take;
    logic              emit;
    logic              cand_load;
    logic              boot_zone;
    logic [23:0]       fat_prod;
    logic [24:0]       root_base;
    logic [OFF_W-1:0]  root_start_calc;
    logic [16:0]       rs_sum;
    logic [RS_CALC_W-1:0] rs_calc;
    logic [OFF_W:0]    rel_full;
    logic              in_root;
    logic [4:0]        ent_pos;
    logic [BYTE_W-1:0] name_byte;
    logic [BYTE_W-1:0] ext_byte;

    // handshake: a request that gives no result always moves on; one that
    // gives a result waits for the candidate slot to free up
    assign cand_free = !cand_v_reg || !cand_stall;
    assign s0_move   = s0_v_reg && (cand_free || !emit);
    assign in_stall  = s0_v_reg && !cand_free && emit;
    assign in_take   = in_valid && !in_stall;

    assign cand_valid = cand_v_reg;
    assign cand       = cand_reg;

    // state as seen by this request, after an optional search restart
    assign sig_eff        = s0_start_reg ? '0   : sig_reg;
    assign ssize_eff      = s0_start_reg ? '0   : ssize_reg;
    assign resv_eff       = s0_start_reg ? '0   : resv_reg;
    assign fatn_eff       = s0_start_reg ? '0   : fatn_reg;
    assign fats_eff       = s0_start_reg ? '0   : fats_reg;
    assign rent_eff       = s0_start_reg ? '0   : rent_reg;
    assign csect_eff      = s0_start_reg ? '0   : csect_reg;
    assign root_start_eff = s0_start_reg ? '0   : root_start_reg;
    assign root_sects_eff = s0_start_reg ? '0   : root_sects_reg;
    assign match_eff      = s0_start_reg ? 1'b1 : match_reg;
    assign clus_eff       = s0_start_reg ? '0   : clus_reg;
    assign done_eff       = s0_start_reg ? 1'b0 : done_reg;
    assign boot_ok_eff    = s0_start_reg ? 1'b0 : boot_ok_reg;

    // boot field positions live in the first 24 bytes
    assign boot_zone = (s0_off_reg[OFF_W-1:5] == '0) && (s0_off_reg[4:0] <= BOOT_LAST);

    // root directory geometry from the boot fields, last FAT size byte included
    assign fat_prod        = {16'b0, fatn_eff} * {8'b0, fats_next};
    assign root_base       = {9'b0, resv_eff} + {1'b0, fat_prod};
    assign root_start_calc = {2'b0, root_base, 9'b0};
    assign rs_sum          = {1'b0, rent_eff} + 17'd15;
    assign rs_calc         = rs_sum[16:4];

    // position inside the root region
    assign rel_full = {1'b0, s0_off_reg} - {1'b0, root_start_eff};
    assign in_root  = !rel_full[OFF_W]
                      && (rel_full[OFF_W-1:0] < {15'b0, rent_eff, 5'b0});
    assign ent_pos  = rel_full[4:0];

    // wanted name and extension bytes for this entry position
    assign name_byte = wanted_name[{ent_pos[2:0], 3'b000} +: BYTE_W];
    always_comb
    begin
        case (ent_pos[1:0])
            2'd0:    ext_byte = wanted_ext[7:0];
            2'd1:    ext_byte = wanted_ext[15:8];
            2'd2:    ext_byte = wanted_ext[23:16];
            default: ext_byte = wanted_ext[7:0];
        endcase
    end

    // capture boot fields
    always_comb
    begin
        sig_next   = sig_eff;
        ssize_next = ssize_eff;
        resv_next  = resv_eff;
        fatn_next  = fatn_eff;
        fats_next  = fats_eff;
        rent_next  = rent_eff;
        csect_next = csect_eff;
        if (!done_eff && !boot_ok_eff && boot_zone)
        begin
            case (s0_off_reg[4:0])
                BOOT_JMP0:  sig_next[23:16]  = s0_val_reg;
                BOOT_JMP1:  sig_next[15:8]   = s0_val_reg;
                BOOT_JMP2:  sig_next[7:0]    = s0_val_reg;
                BOOT_BPS0:  ssize_next[7:0]  = s0_val_reg;
                BOOT_BPS1:  ssize_next[15:8] = s0_val_reg;
                BOOT_SPC:   csect_next       = s0_val_reg;
                BOOT_RSV0:  resv_next[7:0]   = s0_val_reg;
                BOOT_RSV1:  resv_next[15:8]  = s0_val_reg;
                BOOT_NFAT:  fatn_next        = s0_val_reg;
                BOOT_RENT0: rent_next[7:0]   = s0_val_reg;
                BOOT_RENT1: rent_next[15:8]  = s0_val_reg;
                BOOT_FATS0: fats_next[7:0]   = s0_val_reg;
                BOOT_LAST:  fats_next[15:8]  = s0_val_reg;
                default:    ;
            endcase
        end
    end

    // run checks, match entries, build the result candidate
    always_comb
    begin
        root_start_next = root_start_eff;
        root_sects_next = root_sects_eff;
        match_next      = match_eff;
        clus_next       = clus_eff;
        done_next       = done_eff;
        boot_ok_next    = boot_ok_eff;
        emit            = 1'b0;
        cand_next       = '0;
        cand_next.status = ST_NOT_FOUND;
        if (!done_eff)
        begin
            if (!boot_ok_eff)
            begin
                if (boot_zone && s0_off_reg[4:0] == BOOT_LAST)
                begin
                    if (sig_eff != BOOT_SIG)
                    begin
                        emit             = 1'b1;
                        cand_next.status = ST_BAD_SIG;
                    end
                    else if (ssize_eff != SECTOR_BYTES)
                    begin
                        emit             = 1'b1;
                        cand_next.status = ST_BAD_SECT;
                    end
                    else
                    begin
                        root_start_next = root_start_calc;
                        root_sects_next = rs_calc[RS_W-1:0];
                        if (rs_calc == '0 || rs_calc > RS_LIMIT)
                        begin
                            emit             = 1'b1;
                            cand_next.status = ST_BAD_ROOT;
                        end
                        else
                        begin
                            boot_ok_next = 1'b1;
                        end
                    end
                end
            end
            else if (in_root)
            begin
                case (ent_pos) inside
                    ENT_NAME0:
                        match_next = (s0_val_reg == name_byte);
                    [ENT_NAME1:ENT_NAME7]:
                        if (s0_val_reg != name_byte)
                            match_next = 1'b0;
                    [ENT_EXT0:ENT_EXT2]:
                        if (s0_val_reg != ext_byte)
                            match_next = 1'b0;
                    ENT_CLUS0:
                        clus_next[7:0] = s0_val_reg;
                    ENT_CLUS1:
                    begin
                        clus_next[15:8] = s0_val_reg;
                        if (match_eff)
                        begin
                            emit                 = 1'b1;
                            cand_next.status     = ST_FOUND;
                            cand_next.cluster    = {s0_val_reg, clus_eff[7:0]};
                            cand_next.root_start = root_start_eff;
                            cand_next.root_sects = root_sects_eff;
                            cand_next.clus_sects = csect_eff;
                        end
                    end
                    default: ;
                endcase
            end
            // end of stream without a result
            if (!emit && s0_last_reg)
            begin
                emit             = 1'b1;
                cand_next.status = ST_NOT_FOUND;
            end
            if (emit)
                done_next = 1'b1;
        end
    end

    assign cand_load   = s0_move && emit;
    assign cand_v_next = cand_load ? 1'b1 : (cand_free ? 1'b0 : cand_v_reg);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (in_take)
            s0_v_reg <= 1'b1;
        else if (s0_move)
            s0_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_start_reg <= start_search;
            s0_off_reg   <= byte_offset;
            s0_val_reg   <= byte_value;
            s0_last_reg  <= stream_end;
        end
    end

    // commit search state when the request moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sig_reg        <= '0;
            ssize_reg      <= '0;
            resv_reg       <= '0;
            fatn_reg       <= '0;
            fats_reg       <= '0;
            rent_reg       <= '0;
            csect_reg      <= '0;
            root_start_reg <= '0;
            root_sects_reg <= '0;
            match_reg      <= 1'b1;
            clus_reg       <= '0;
            done_reg       <= 1'b0;
            boot_ok_reg    <= 1'b0;
        end
        else if (s0_move)
        begin
            sig_reg        <= sig_next;
            ssize_reg      <= ssize_next;
            resv_reg       <= resv_next;
            fatn_reg       <= fatn_next;
            fats_reg       <= fats_next;
            rent_reg       <= rent_next;
            csect_reg      <= csect_next;
            root_start_reg <= root_start_next;
            root_sects_reg <= root_sects_next;
            match_reg      <= match_next;
            clus_reg       <= clus_next;
            done_reg       <= done_next;
            boot_ok_reg    <= boot_ok_next;
        end
    end

    // result candidate register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cand_v_reg <= 1'b0;
        else
            cand_v_reg <= cand_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (cand_load)
            cand_reg <= cand_next;
    end

    `FRFL_ASSERT_NEXT(a_one_result_per_search, cand_load, done_reg,
        "result given but search not marked done")
    `FRFL_ASSERT_IMPL(a_quiet_after_result, s0_move && done_reg && !s0_start_reg,
        !cand_load, "result given after search finished")
    `FRFL_ASSERT_IMPL(a_root_size_checked, boot_ok_reg,
        root_sects_reg != '0 && RS_CALC_W'(root_sects_reg) <= RS_LIMIT,
        "boot accepted with root size out of range")

endmodule

FILE: sv/frfl_offset.sv
// Two-stage computation of the first block offset and the result register.
// Depends on frfl_pkg and the assertion macro header.
`include "fat_root_file_locator_top_macros.svh"

module frfl_offset
    import frfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  frfl_cand_t        cand,
    output logic              cand_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [STATUS_W-1:0] status,
    output logic signed [FOFF_W-1:0] file_offset,
    output logic [CLUS_W-1:0] start_cluster
);

    // first stage: data area base and cluster product
    logic                    p2_v_reg;
    frfl_status_t            p2_status_reg;
    logic [CLUS_W-1:0]       p2_cluster_reg;
    logic [OFF_W:0]          p2_base_reg;
    logic signed [25:0]      p2_prod_reg;

    // result register
    logic                    out_v_reg;
    frfl_status_t            status_reg;
    logic signed [FOFF_W-1:0] foff_reg;
    logic [CLUS_W-1:0]       clus_reg;

    logic                    out_free;
    logic                    p2_free;
    logic                    cand_take;
    logic signed [16:0]      clus_m2;
    logic signed [25:0]      prod;
    logic [OFF_W:0]          base;
    logic signed [FOFF_W-1:0] foff_next;

    assign out_free   = !out_v_reg || !out_stall;
    assign p2_free    = !p2_v_reg || out_free;
    assign cand_stall = cand_valid && !p2_free;
    assign cand_take  = cand_valid && p2_free;

    // cluster index relative to the first data cluster, times cluster size
    assign clus_m2 = $signed({1'b0, cand.cluster}) - 17'sd2;
    assign prod    = $signed({{9{clus_m2[16]}}, clus_m2})
                     * $signed({17'b0, cand.clus_sects});
    assign base    = {1'b0, cand.root_start} + {19'b0, cand.root_sects, 9'b0};

    // add sector-scaled product to the base, zero for error results
    always_comb
    begin
        if (p2_status_reg == ST_FOUND)
            foff_next = $signed({4'b0, p2_base_reg})
                        + $signed({{6{p2_prod_reg[25]}}, p2_prod_reg, 9'b0});
        else
            foff_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (p2_free)
                p2_v_reg <= cand_take;
            if (out_free)
                out_v_reg <= p2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_take)
        begin
            p2_status_reg  <= cand.status;
            p2_cluster_reg <= cand.cluster;
            p2_base_reg    <= base;
            p2_prod_reg    <= prod;
        end
        if (out_free && p2_v_reg)
        begin
            status_reg <= p2_status_reg;
            foff_reg   <= foff_next;
            clus_reg   <= (p2_status_reg == ST_FOUND) ? p2_cluster_reg : '0;
        end
    end

    assign out_valid     = out_v_reg;
    assign status        = status_reg;
    assign file_offset   = foff_reg;
    assign start_cluster = clus_reg;

    `FRFL_ASSERT_IMPL(a_error_fields_zero, out_v_reg && status_reg != ST_FOUND,
        file_offset == '0 && start_cluster == '0, "error result carries nonzero fields")
    `FRFL_ASSERT_NEXT(a_stage_held_on_stall, p2_v_reg && out_v_reg && out_stall,
        p2_v_reg, "offset stage dropped a request while output stalled")

endmodule

FILE: sv/fat_root_file_locator_top.sv
// Top level of the FAT16 root directory file locator: configuration registers
// and the scan and offset stages. Depends on frfl_pkg, frfl_scan, frfl_offset.
//
// The block takes one disk byte per cycle, tagged with its disk offset. A byte
// that gives no result is never held back; a byte that gives a result waits
// only while the candidate, offset and result registers are all full and the
// result side stalls. A byte passes an input register, the scan stage (boot
// field capture, boot checks with an 8x16 multiply for the root start, or one
// name compare), and two offset stages before its result is presented. At
// most one result is given per search: found with the first block offset, a
// boot sector error, or not found at end of stream. The wanted 8.3 name is
// written through the configuration port; the user must write it only while
// the block is idle, which the block itself does not enforce.

module fat_root_file_locator_top
    import frfl_pkg::*;
#(
    parameter int MAX_ROOT_SECTORS = DEF_MAX_ROOT_SECTORS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [NAME_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     start_search,
    input  logic [OFF_W-1:0]         byte_offset,
    input  logic [BYTE_W-1:0]        byte_value,
    input  logic                     stream_end,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic signed [FOFF_W-1:0] file_offset,
    output logic [CLUS_W-1:0]        start_cluster
);

    logic [NAME_W-1:0] name_reg;
    logic [EXT_W-1:0]  ext_reg;
    logic              cand_valid;
    logic              cand_stall;
    frfl_cand_t        cand;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg <= NAME_RESET;
            ext_reg  <= EXT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WANTED_NAME: name_reg <= cfg_data;
                REG_WANTED_EXT:  ext_reg  <= cfg_data[EXT_W-1:0];
                default:         ;
            endcase
        end
    end

    frfl_scan #(
        .MAX_ROOT_SECTORS (MAX_ROOT_SECTORS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_search (start_search),
        .byte_offset  (byte_offset),
        .byte_value   (byte_value),
        .stream_end   (stream_end),
        .wanted_name  (name_reg),
        .wanted_ext   (ext_reg),
        .cand_valid   (cand_valid),
        .cand         (cand),
        .cand_stall   (cand_stall)
    );

    frfl_offset u_offset (
        .clk           (clk),
        .rst_n         (rst_n),
        .cand_valid    (cand_valid),
        .cand          (cand),
        .cand_stall    (cand_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .file_offset   (file_offset),
        .start_cluster (start_cluster)
    );

endmodule
